FILE: src/led_light_priority_sequencer_defines.svh
// Assertion macros shared by the light request sequencer RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef LED_LIGHT_PRIORITY_SEQUENCER_DEFINES_SVH
`define LED_LIGHT_PRIORITY_SEQUENCER_DEFINES_SVH
`ifndef SYNTHESIS
`define LLPS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("llps assertion failed");
`define LLPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("llps assertion failed");
`else
`define LLPS_ASSERT(label, clk, rst_n, prop)
`define LLPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/llps_pkg.sv
// Shared constants, types and tables of the light request sequencer.
// Used by the interfaces, the controller, the datapath and the divide unit.
package llps_pkg;

    localparam int TIME_BITS_DEF = 24;

    localparam int KIND_W       = 3;
    localparam int COLOR_W      = 32;
    localparam int FIELD_TIME_W = 24;
    localparam int TARGET_W     = 4;
    localparam int VALUE_W      = 24;
    localparam int MAX_W        = 12;
    localparam int LUMA_W       = 8;
    localparam int PROD_W       = LUMA_W + MAX_W;
    localparam int QUOT_W       = 12;

    localparam int RAMP_STEPS  = 8;
    localparam int RAMP_IDX_W  = $clog2(RAMP_STEPS);
    localparam int STEP_MS     = 50;
    localparam int RAMP_SPAN   = STEP_MS * RAMP_STEPS * 2;
    localparam int RAMP_SHIFT  = $clog2(RAMP_STEPS * 2);
    localparam int NUM_CLEARS  = 5;

    localparam int FULL_SCALE     = 255;
    localparam int BATT_LOW_LEVEL = 10;
    localparam int LUMA_R         = 77;
    localparam int LUMA_G         = 150;
    localparam int LUMA_B         = 29;

    localparam logic [MAX_W-1:0] PANEL_MAX_RESET = MAX_W'(FULL_SCALE);

    localparam int NUM_SOURCES   = 3;
    localparam int SRC_IDX_W     = 2;
    localparam int SRC_ATTENTION = 0;
    localparam int SRC_BATTERY   = 1;
    localparam int SRC_NOTIFY    = 2;

    localparam logic [KIND_W-1:0] KIND_BACKLIGHT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ATTENTION = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BATTERY   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NOTIFY    = 3'd3;

    localparam logic [TARGET_W-1:0] TGT_BACKLIGHT  = 4'd0;
    localparam logic [TARGET_W-1:0] TGT_RED        = 4'd1;
    localparam logic [TARGET_W-1:0] TGT_RED_BLINK  = 4'd2;
    localparam logic [TARGET_W-1:0] TGT_GREEN      = 4'd3;
    localparam logic [TARGET_W-1:0] TGT_BLUE       = 4'd4;
    localparam logic [TARGET_W-1:0] TGT_BLUE_BLINK = 4'd5;
    localparam logic [TARGET_W-1:0] TGT_START_IDX  = 4'd6;
    localparam logic [TARGET_W-1:0] TGT_DUTY       = 4'd7;
    localparam logic [TARGET_W-1:0] TGT_PAUSE_LO   = 4'd8;
    localparam logic [TARGET_W-1:0] TGT_PAUSE_HI   = 4'd9;
    localparam logic [TARGET_W-1:0] TGT_STEP       = 4'd10;
    localparam logic [TARGET_W-1:0] TGT_NONE       = 4'd11;

    typedef enum logic [2:0] {
        VAL_ZERO,
        VAL_ONE,
        VAL_QUOT,
        VAL_ALPHA,
        VAL_OFF,
        VAL_HI,
        VAL_STEP
    } val_sel_t;

    typedef struct packed {
        logic                  capture;
        logic                  luma_en;
        logic                  mul_en;
        logic                  mul_duty;
        logic                  div_en;
        logic                  load_out;
        logic                  status;
        logic [TARGET_W-1:0]   target;
        val_sel_t              val_sel;
        logic [RAMP_IDX_W-1:0] duty_idx;
        logic                  last;
    } llps_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              any_lit;
        logic              batt_only;
        logic              batt_high;
        logic              blink;
    } llps_stat_t;

    function automatic logic [6:0] ramp_pct(input logic [RAMP_IDX_W-1:0] k);
        logic [6:0] pct;
        case (k)
            3'd0:    pct = 7'd0;
            3'd1:    pct = 7'd12;
            3'd2:    pct = 7'd25;
            3'd3:    pct = 7'd37;
            3'd4:    pct = 7'd50;
            3'd5:    pct = 7'd72;
            3'd6:    pct = 7'd85;
            3'd7:    pct = 7'd100;
            default: pct = 7'd0;
        endcase
        return pct;
    endfunction

    // The clearing writes go out in this fixed order.
    function automatic logic [TARGET_W-1:0] clear_target(input logic [RAMP_IDX_W-1:0] n);
        logic [TARGET_W-1:0] t;
        case (n)
            3'd0:    t = TGT_RED;
            3'd1:    t = TGT_RED_BLINK;
            3'd2:    t = TGT_GREEN;
            3'd3:    t = TGT_BLUE;
            3'd4:    t = TGT_BLUE_BLINK;
            default: t = TGT_NONE;
        endcase
        return t;
    endfunction

endpackage

FILE: src/llps_req_if.sv
// Request channel of the light request sequencer: valid, ready and one request item.
// Depends on llps_pkg for the field widths.
interface llps_req_if;
    import llps_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic [COLOR_W-1:0]      color;
    logic                    flash_timed;
    logic [FIELD_TIME_W-1:0] on_time_ms;
    logic [FIELD_TIME_W-1:0] off_time_ms;

    modport source (output valid, kind, color, flash_timed, on_time_ms, off_time_ms,
                    input ready);
    modport sink (input valid, kind, color, flash_timed, on_time_ms, off_time_ms,
                  output ready);
endinterface

FILE: src/llps_rsp_if.sv
// Result channel of the light request sequencer: valid, ready and one register write item.
// Depends on llps_pkg for the field widths.
interface llps_rsp_if;
    import llps_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  status;
    logic [TARGET_W-1:0]   target;
    logic [VALUE_W-1:0]    value;
    logic [RAMP_IDX_W-1:0] duty_index;
    logic                  last;

    modport source (output valid, status, target, value, duty_index, last, input ready);
    modport sink (input valid, status, target, value, duty_index, last, output ready);
endinterface

FILE: src/llps_div255.sv
// Two-step divide by 255 for products of up to PROD_W bits.
// Depends on llps_pkg; used by llps_datapath.
module llps_div255 (
    input  logic                        clk,
    input  logic                        start,
    input  logic [llps_pkg::PROD_W-1:0] dividend,
    output logic [llps_pkg::QUOT_W-1:0] quotient
);
    import llps_pkg::*;

    localparam int EST_W = PROD_W + 8;

    logic [EST_W-1:0]  approx;
    logic [PROD_W-1:0] x_reg;
    logic [QUOT_W-1:0] qest_reg;
    logic [PROD_W-1:0] back;
    logic [PROD_W-1:0] rem;

    // x * 257 / 65536 never overshoots x / 255 and falls short by at most one.
    assign approx = {dividend, 8'b0} + EST_W'(dividend);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= dividend;
            qest_reg <= approx[EST_W-1:16];
        end
    end

    assign back     = PROD_W'({qest_reg, 8'b0}) - PROD_W'(qest_reg);
    assign rem      = x_reg - back;
    assign quotient = qest_reg + QUOT_W'(rem >= PROD_W'(FULL_SCALE));

endmodule

FILE: src/llps_datapath.sv
// Datapath of the light request sequencer: source store, luma and duty arithmetic,
// output register. Depends on llps_pkg and llps_div255.
module llps_datapath #(
    parameter int TIME_BITS = llps_pkg::TIME_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [llps_pkg::MAX_W-1:0]        cfg_wdata,
    input  logic [llps_pkg::KIND_W-1:0]       req_kind,
    input  logic [llps_pkg::COLOR_W-1:0]      req_color,
    input  logic                              req_flash_timed,
    input  logic [llps_pkg::FIELD_TIME_W-1:0] req_on_time,
    input  logic [llps_pkg::FIELD_TIME_W-1:0] req_off_time,
    input  llps_pkg::llps_cmd_t               cmd,
    output llps_pkg::llps_stat_t              stat,
    output logic                              status,
    output logic [llps_pkg::TARGET_W-1:0]     target,
    output logic [llps_pkg::VALUE_W-1:0]      value,
    output logic [llps_pkg::RAMP_IDX_W-1:0]   duty_index,
    output logic                              last
);
    import llps_pkg::*;

    logic [MAX_W-1:0]     panel_max_reg;
    logic [KIND_W-1:0]    kind_reg;
    logic [COLOR_W-1:0]   color_reg;
    logic [COLOR_W-1:0]   src_color_reg [NUM_SOURCES];
    logic [TIME_BITS-1:0] src_on_reg    [NUM_SOURCES];
    logic [TIME_BITS-1:0] src_off_reg   [NUM_SOURCES];
    logic [LUMA_W-1:0]    luma_reg;
    logic [PROD_W-1:0]    mul_reg;

    logic                 store_we;
    logic [SRC_IDX_W-1:0] wr_idx;
    logic [TIME_BITS-1:0] on_in;
    logic [TIME_BITS-1:0] off_in;
    logic                 lit_attn;
    logic                 lit_batt;
    logic                 lit_notify;
    logic [COLOR_W-1:0]   sel_color;
    logic [TIME_BITS-1:0] sel_on;
    logic [TIME_BITS-1:0] sel_off;
    logic [7:0]           alpha;
    logic [15:0]          luma_sum;
    logic [LUMA_W-1:0]    mul_a;
    logic [MAX_W-1:0]     mul_b;
    logic [PROD_W-1:0]    mul_prod;
    logic [QUOT_W-1:0]    quot;
    logic                 short_on;
    logic [VALUE_W-1:0]   step_val;
    logic [VALUE_W-1:0]   hi_val;
    logic [VALUE_W-1:0]   value_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_max_reg <= PANEL_MAX_RESET;
        end
        else if (cfg_we)
        begin
            panel_max_reg <= cfg_wdata;
        end
    end

    assign store_we = req_kind inside {KIND_ATTENTION, KIND_BATTERY, KIND_NOTIFY};
    assign wr_idx   = SRC_IDX_W'(req_kind - KIND_ATTENTION);
    assign on_in    = req_flash_timed ? TIME_BITS'(req_on_time) : '0;
    assign off_in   = req_flash_timed ? TIME_BITS'(req_off_time) : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg  <= req_kind;
            color_reg <= req_color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                src_color_reg[i] <= '0;
                src_on_reg[i]    <= '0;
                src_off_reg[i]   <= '0;
            end
        end
        else if (cmd.capture && store_we)
        begin
            src_color_reg[wr_idx] <= req_color;
            src_on_reg[wr_idx]    <= on_in;
            src_off_reg[wr_idx]   <= off_in;
        end
    end

    assign lit_attn   = |src_color_reg[SRC_ATTENTION][23:0];
    assign lit_batt   = |src_color_reg[SRC_BATTERY][23:0];
    assign lit_notify = |src_color_reg[SRC_NOTIFY][23:0];

    // Notification wins over attention; battery is served only when neither is lit.
    always_comb
    begin
        if (lit_notify)
        begin
            sel_color = src_color_reg[SRC_NOTIFY];
            sel_on    = src_on_reg[SRC_NOTIFY];
            sel_off   = src_off_reg[SRC_NOTIFY];
        end
        else if (lit_attn)
        begin
            sel_color = src_color_reg[SRC_ATTENTION];
            sel_on    = src_on_reg[SRC_ATTENTION];
            sel_off   = src_off_reg[SRC_ATTENTION];
        end
        else
        begin
            sel_color = src_color_reg[SRC_BATTERY];
            sel_on    = src_on_reg[SRC_BATTERY];
            sel_off   = src_off_reg[SRC_BATTERY];
        end
    end

    assign alpha = sel_color[31:24];

    assign stat.kind      = kind_reg;
    assign stat.any_lit   = lit_notify | lit_attn | lit_batt;
    assign stat.batt_only = !lit_notify && !lit_attn;
    assign stat.batt_high = src_color_reg[SRC_BATTERY][31:24] > 8'(BATT_LOW_LEVEL);
    assign stat.blink     = (sel_on != '0) && (sel_off != '0);

    assign luma_sum = 16'(LUMA_R) * 16'(color_reg[23:16])
                    + 16'(LUMA_G) * 16'(color_reg[15:8])
                    + 16'(LUMA_B) * 16'(color_reg[7:0]);

    // One multiplier serves the backlight scaling and the duty percentages.
    assign mul_a    = cmd.mul_duty ? LUMA_W'(ramp_pct(cmd.duty_idx)) : luma_reg;
    assign mul_b    = cmd.mul_duty ? MAX_W'(alpha) : panel_max_reg;
    assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_ff @(posedge clk)
    begin
        if (cmd.luma_en)
        begin
            luma_reg <= luma_sum[15:8];
        end
        if (cmd.mul_en)
        begin
            mul_reg <= mul_prod;
        end
    end

    llps_div255 u_div (
        .clk      (clk),
        .start    (cmd.div_en),
        .dividend (mul_reg),
        .quotient (quot)
    );

    assign short_on = sel_on < TIME_BITS'(RAMP_SPAN);
    assign step_val = short_on ? VALUE_W'(sel_on >> RAMP_SHIFT) : VALUE_W'(STEP_MS);
    assign hi_val   = short_on ? '0 : VALUE_W'(sel_on - TIME_BITS'(RAMP_SPAN));

    always_comb
    begin
        case (cmd.val_sel)
            VAL_ZERO:  value_next = '0;
            VAL_ONE:   value_next = VALUE_W'(1);
            VAL_QUOT:  value_next = VALUE_W'(quot);
            VAL_ALPHA: value_next = VALUE_W'(alpha);
            VAL_OFF:   value_next = VALUE_W'(sel_off);
            VAL_HI:    value_next = hi_val;
            VAL_STEP:  value_next = step_val;
            default:   value_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            status     <= cmd.status;
            target     <= cmd.target;
            value      <= value_next;
            duty_index <= cmd.duty_idx;
            last       <= cmd.last;
        end
    end

endmodule

FILE: src/llps_ctrl.sv
// Controller of the light request sequencer: steps through the writes of one request.
// Depends on llps_pkg and the assertion macros header.
`include "led_light_priority_sequencer_defines.svh"

module llps_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  llps_pkg::llps_stat_t stat,
    output llps_pkg::llps_cmd_t  cmd
);
    import llps_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_LUMA,
        S_MUL,
        S_DIV,
        S_FIN,
        S_NONE,
        S_CLEAR,
        S_SERVE,
        S_DUTY_MUL,
        S_DUTY_DIV,
        S_DUTY_FIN,
        S_PAUSE_LO,
        S_PAUSE_HI,
        S_STEP,
        S_BLINK_ON,
        S_WAIT
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    state_t                resume_reg;
    state_t                resume_next;
    logic [RAMP_IDX_W-1:0] cnt_reg;
    logic [RAMP_IDX_W-1:0] cnt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    always_comb
    begin
        cmd            = '0;
        cmd.val_sel    = VAL_ZERO;
        cmd.target     = TGT_NONE;
        state_next     = state_reg;
        resume_next    = resume_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cnt_next = '0;
                if (stat.kind == KIND_BACKLIGHT)
                begin
                    state_next = S_LUMA;
                end
                else if (stat.kind inside {KIND_ATTENTION, KIND_BATTERY, KIND_NOTIFY})
                begin
                    state_next = S_CLEAR;
                end
                else
                begin
                    state_next = S_NONE;
                end
            end
            S_LUMA:
            begin
                cmd.luma_en = 1'b1;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_en = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.load_out   = 1'b1;
                cmd.target     = TGT_BACKLIGHT;
                cmd.val_sel    = VAL_QUOT;
                cmd.last       = 1'b1;
                out_valid_next = 1'b1;
                resume_next    = S_IDLE;
                state_next     = S_WAIT;
            end
            S_NONE:
            begin
                cmd.load_out   = 1'b1;
                cmd.status     = 1'b1;
                cmd.target     = TGT_NONE;
                cmd.last       = 1'b1;
                out_valid_next = 1'b1;
                resume_next    = S_IDLE;
                state_next     = S_WAIT;
            end
            S_CLEAR:
            begin
                cmd.load_out   = 1'b1;
                cmd.target     = clear_target(cnt_reg);
                out_valid_next = 1'b1;
                state_next     = S_WAIT;
                if (cnt_reg == RAMP_IDX_W'(NUM_CLEARS - 1))
                begin
                    // With nothing lit the last clearing write ends the request.
                    cmd.last    = !stat.any_lit;
                    cnt_next    = '0;
                    resume_next = stat.any_lit ? S_SERVE : S_IDLE;
                end
                else
                begin
                    cnt_next    = cnt_reg + 1'b1;
                    resume_next = S_CLEAR;
                end
            end
            S_SERVE:
            begin
                cmd.load_out   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_WAIT;
                if (stat.batt_only)
                begin
                    cmd.target  = stat.batt_high ? TGT_GREEN : TGT_RED;
                    cmd.val_sel = VAL_ONE;
                    cmd.last    = 1'b1;
                    resume_next = S_IDLE;
                end
                else if (!stat.blink)
                begin
                    cmd.target  = TGT_BLUE;
                    cmd.val_sel = VAL_ALPHA;
                    cmd.last    = 1'b1;
                    resume_next = S_IDLE;
                end
                else
                begin
                    cmd.target  = TGT_START_IDX;
                    cnt_next    = '0;
                    resume_next = S_DUTY_MUL;
                end
            end
            S_DUTY_MUL:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_duty = 1'b1;
                cmd.duty_idx = cnt_reg;
                state_next   = S_DUTY_DIV;
            end
            S_DUTY_DIV:
            begin
                cmd.div_en = 1'b1;
                state_next = S_DUTY_FIN;
            end
            S_DUTY_FIN:
            begin
                cmd.load_out   = 1'b1;
                cmd.target     = TGT_DUTY;
                cmd.val_sel    = VAL_QUOT;
                cmd.duty_idx   = cnt_reg;
                out_valid_next = 1'b1;
                state_next     = S_WAIT;
                cnt_next       = cnt_reg + 1'b1;
                resume_next    = (cnt_reg == RAMP_IDX_W'(RAMP_STEPS - 1)) ? S_PAUSE_LO
                                                                          : S_DUTY_MUL;
            end
            S_PAUSE_LO:
            begin
                cmd.load_out   = 1'b1;
                cmd.target     = TGT_PAUSE_LO;
                cmd.val_sel    = VAL_OFF;
                out_valid_next = 1'b1;
                resume_next    = S_PAUSE_HI;
                state_next     = S_WAIT;
            end
            S_PAUSE_HI:
            begin
                cmd.load_out   = 1'b1;
                cmd.target     = TGT_PAUSE_HI;
                cmd.val_sel    = VAL_HI;
                out_valid_next = 1'b1;
                resume_next    = S_STEP;
                state_next     = S_WAIT;
            end
            S_STEP:
            begin
                cmd.load_out   = 1'b1;
                cmd.target     = TGT_STEP;
                cmd.val_sel    = VAL_STEP;
                out_valid_next = 1'b1;
                resume_next    = S_BLINK_ON;
                state_next     = S_WAIT;
            end
            S_BLINK_ON:
            begin
                cmd.load_out   = 1'b1;
                cmd.target     = TGT_BLUE_BLINK;
                cmd.val_sel    = VAL_ONE;
                cmd.last       = 1'b1;
                out_valid_next = 1'b1;
                resume_next    = S_IDLE;
                state_next     = S_WAIT;
            end
            S_WAIT:
            begin
                if (rsp_ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = resume_reg;
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
                state_next     = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            resume_reg    <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            resume_reg    <= resume_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    `LLPS_ASSERT(a_wait_matches_valid, clk, rst_n, (state_reg == S_WAIT) == out_valid_reg)
    `LLPS_ASSERT_NEXT(a_accept_dispatch, clk, rst_n, req_valid && req_ready, state_reg == S_DISPATCH)
    `LLPS_ASSERT_NEXT(a_load_shows_item, clk, rst_n, cmd.load_out, out_valid_reg && !req_ready)
    `LLPS_ASSERT(a_clear_count, clk, rst_n, state_reg != S_CLEAR || cnt_reg < RAMP_IDX_W'(NUM_CLEARS))

endmodule

FILE: src/led_light_priority_sequencer.sv
// Top level of the light request sequencer: controller, datapath and channel hookup.
// Depends on llps_pkg, llps_req_if, llps_rsp_if, llps_ctrl and llps_datapath.

// One request is handled at a time; the request side is ready only while no write is
// pending. Every result item leaves through a single output register, loaded and then
// handed off; the luma and each duty percentage pass through the shared multiplier and
// the two-step divide by 255, and the backlight write forms the luma first. The three
// stored sources reset to unlit; the panel maximum resets to 255 and may be written any
// time the block is idle.
module led_light_priority_sequencer #(
    parameter int TIME_BITS = llps_pkg::TIME_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [llps_pkg::MAX_W-1:0] cfg_wdata,
    llps_req_if.sink                   req,
    llps_rsp_if.source                 rsp
);
    import llps_pkg::*;

    llps_cmd_t  cmd;
    llps_stat_t stat;

    llps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    llps_datapath #(
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .req_kind        (req.kind),
        .req_color       (req.color),
        .req_flash_timed (req.flash_timed),
        .req_on_time     (req.on_time_ms),
        .req_off_time    (req.off_time_ms),
        .cmd             (cmd),
        .stat            (stat),
        .status          (rsp.status),
        .target          (rsp.target),
        .value           (rsp.value),
        .duty_index      (rsp.duty_index),
        .last            (rsp.last)
    );

endmodule

FILE: test/led_light_priority_sequencer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the light request sequencer: directed and random requests,
// panel maximum changes between phases, random stalls on both channels.
// Depends on llps_pkg, llps_req_if, llps_rsp_if and led_light_priority_sequencer.
module led_light_priority_sequencer_tb;
    import llps_pkg::*;

    localparam int          CLK_HALF_NS   = 5;
    localparam int          RESET_CYCLES  = 6;
    localparam int          IDLE_PCT      = 19;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          SETTLE_CYCLES = 60;
    localparam int          PRINT_CAP     = 40;
    localparam int          TIMEOUT_NS    = 2000000;
    localparam logic        STATUS_OK     = 1'b0;
    localparam logic        STATUS_UNSUP  = 1'b1;
    localparam logic [KIND_W-1:0] KIND_UNSUP_LO = 3'd4;
    localparam logic [KIND_W-1:0] KIND_UNSUP_HI = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [COLOR_W-1:0]      color;
        logic                    flash_timed;
        logic [FIELD_TIME_W-1:0] on_time_ms;
        logic [FIELD_TIME_W-1:0] off_time_ms;
    } light_req_t;

    typedef struct packed {
        logic                  status;
        logic [TARGET_W-1:0]   target;
        logic [VALUE_W-1:0]    value;
        logic [RAMP_IDX_W-1:0] duty_index;
        logic                  last;
    } reg_write_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [MAX_W-1:0] cfg_wdata;

    llps_req_if req_ch ();
    llps_rsp_if rsp_ch ();

    led_light_priority_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Requests waiting to be offered, and register writes the block still owes.
    light_req_t pending_reqs[$];
    reg_write_t owed_writes[$];

    // Shadow of the block's state.
    logic [MAX_W-1:0]        panel_max_shadow;
    logic [COLOR_W-1:0]      src_color[NUM_SOURCES];
    logic [FIELD_TIME_W-1:0] src_on[NUM_SOURCES];
    logic [FIELD_TIME_W-1:0] src_off[NUM_SOURCES];

    int unsigned duty_pct[RAMP_STEPS] = '{0, 12, 25, 37, 50, 72, 85, 100};

    int   error_count = 0;
    bit   no_idle = 1'b0;
    int   rsp_hold_left = 0;
    logic req_taken;

    always #(CLK_HALF_NS) clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP)
            $display("%0t ns: mismatch: %s", $time, msg);
        error_count++;
    endtask

    function automatic reg_write_t mk_write(input logic st, input logic [TARGET_W-1:0] tgt,
                                            input int unsigned val,
                                            input int unsigned didx);
        reg_write_t w;
        w.status     = st;
        w.target     = tgt;
        w.value      = VALUE_W'(val);
        w.duty_index = RAMP_IDX_W'(didx);
        w.last       = 1'b0;
        return w;
    endfunction

    // Appends one write to the tail of the owed list.
    function automatic void owe_write(input reg_write_t w);
        owed_writes.insert(owed_writes.size(), w);
    endfunction

    // Works out the register writes that one accepted request causes.
    function automatic void predict_writes(input light_req_t r);
        int unsigned luma;
        int unsigned alpha;
        int unsigned step_ms;
        int unsigned pause_hi;
        int          s;
        int          sel;
        if (r.kind == KIND_BACKLIGHT)
        begin
            luma = (LUMA_R * r.color[23:16] + LUMA_G * r.color[15:8]
                    + LUMA_B * r.color[7:0]) >> 8;
            if (panel_max_shadow != FULL_SCALE)
                luma = luma * panel_max_shadow / FULL_SCALE;
            owe_write(mk_write(STATUS_OK, TGT_BACKLIGHT, luma, 0));
        end
        else if (r.kind <= KIND_NOTIFY)
        begin
            s = int'(r.kind) - 1;
            src_color[s] = r.color;
            src_on[s]    = r.flash_timed ? r.on_time_ms : '0;
            src_off[s]   = r.flash_timed ? r.off_time_ms : '0;
            owe_write(mk_write(STATUS_OK, TGT_RED, 0, 0));
            owe_write(mk_write(STATUS_OK, TGT_RED_BLINK, 0, 0));
            owe_write(mk_write(STATUS_OK, TGT_GREEN, 0, 0));
            owe_write(mk_write(STATUS_OK, TGT_BLUE, 0, 0));
            owe_write(mk_write(STATUS_OK, TGT_BLUE_BLINK, 0, 0));
            // Notification wins over attention; battery only when neither is lit.
            sel = -1;
            if (src_color[SRC_NOTIFY][23:0] != 0)
                sel = SRC_NOTIFY;
            else if (src_color[SRC_ATTENTION][23:0] != 0)
                sel = SRC_ATTENTION;
            if (sel >= 0)
            begin
                alpha = src_color[sel][31:24];
                if (src_on[sel] != 0 && src_off[sel] != 0)
                begin
                    if (src_on[sel] < RAMP_SPAN)
                    begin
                        step_ms  = src_on[sel] / (RAMP_STEPS * 2);
                        pause_hi = 0;
                    end
                    else
                    begin
                        step_ms  = STEP_MS;
                        pause_hi = src_on[sel] - RAMP_SPAN;
                    end
                    owe_write(mk_write(STATUS_OK, TGT_START_IDX, 0, 0));
                    for (int k = 0; k < RAMP_STEPS; k++)
                        owe_write(mk_write(STATUS_OK, TGT_DUTY,
                                           duty_pct[k] * alpha / FULL_SCALE, k));
                    owe_write(mk_write(STATUS_OK, TGT_PAUSE_LO, src_off[sel], 0));
                    owe_write(mk_write(STATUS_OK, TGT_PAUSE_HI, pause_hi, 0));
                    owe_write(mk_write(STATUS_OK, TGT_STEP, step_ms, 0));
                    owe_write(mk_write(STATUS_OK, TGT_BLUE_BLINK, 1, 0));
                end
                else
                begin
                    owe_write(mk_write(STATUS_OK, TGT_BLUE, alpha, 0));
                end
            end
            else if (src_color[SRC_BATTERY][23:0] != 0)
            begin
                if (src_color[SRC_BATTERY][31:24] > BATT_LOW_LEVEL)
                    owe_write(mk_write(STATUS_OK, TGT_GREEN, 1, 0));
                else
                    owe_write(mk_write(STATUS_OK, TGT_RED, 1, 0));
            end
        end
        else
        begin
            owe_write(mk_write(STATUS_UNSUP, TGT_NONE, 0, 0));
        end
        owed_writes[owed_writes.size() - 1].last = 1'b1;
    endfunction

    function automatic logic [FIELD_TIME_W-1:0] rand_time_ms();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return '0;
        else if (pick < 45)
            return FIELD_TIME_W'($urandom_range(1000, 1));
        else if (pick < 80)
            return FIELD_TIME_W'($urandom_range(20000, RAMP_SPAN));
        else
            return FIELD_TIME_W'($urandom());
    endfunction

    // Mostly well-formed light requests, with unlit colors so that lower priorities show.
    function automatic light_req_t rand_light_req();
        light_req_t  r;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 20)
            r.kind = KIND_BACKLIGHT;
        else if (pick < 88)
            r.kind = KIND_ATTENTION + KIND_W'($urandom_range(2));
        else
            r.kind = KIND_UNSUP_LO + KIND_W'($urandom_range(3));
        r.color = $urandom();
        if ($urandom_range(99) < 35)
            r.color[23:0] = '0;
        if ($urandom_range(99) < 20)
            r.color[31:24] = 8'($urandom_range(20));
        r.flash_timed = ($urandom_range(99) < 65);
        r.on_time_ms  = rand_time_ms();
        r.off_time_ms = rand_time_ms();
        return r;
    endfunction

    task automatic add_req(input logic [KIND_W-1:0] k, input logic [COLOR_W-1:0] c,
                           input logic ft, input logic [FIELD_TIME_W-1:0] on_ms,
                           input logic [FIELD_TIME_W-1:0] off_ms);
        light_req_t r;
        r.kind        = k;
        r.color       = c;
        r.flash_timed = ft;
        r.on_time_ms  = on_ms;
        r.off_time_ms = off_ms;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic queue_random(input int n);
        repeat (n) pending_reqs.insert(pending_reqs.size(), rand_light_req());
    endtask

    // Waits until every request is taken and every owed write has come back.
    task automatic drain();
        while (!(pending_reqs.size() == 0 && !req_ch.valid && owed_writes.size() == 0))
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_panel_max(input logic [MAX_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        panel_max_shadow = v;
    endtask

    // Request driver.
    always @(negedge clk)
    begin : drive_req
        light_req_t nxt;
        if (rst_n && (!req_ch.valid || req_taken))
        begin
            if (pending_reqs.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT))
            begin
                nxt = pending_reqs.pop_front();
                req_ch.valid       <= 1'b1;
                req_ch.kind        <= nxt.kind;
                req_ch.color       <= nxt.color;
                req_ch.flash_timed <= nxt.flash_timed;
                req_ch.on_time_ms  <= nxt.on_time_ms;
                req_ch.off_time_ms <= nxt.off_time_ms;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Result side ready, with an optional long hold-off.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_hold_left > 0)
            begin
                rsp_ch.ready  <= 1'b0;
                rsp_hold_left <= rsp_hold_left - 1;
            end
            else
            begin
                rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Monitor: checks each write item against the oldest owed one, then predicts new ones.
    always @(posedge clk)
    begin : monitor
        reg_write_t want;
        light_req_t seen;
        req_taken <= rst_n && req_ch.valid && req_ch.ready;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (owed_writes.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected write target %0d value 0x%0h",
                                              rsp_ch.target, rsp_ch.value));
                end
                else
                begin
                    want = owed_writes.pop_front();
                    if (rsp_ch.status !== want.status)
                        report_mismatch($sformatf("status %0b, wanted %0b",
                                                  rsp_ch.status, want.status));
                    if (rsp_ch.target !== want.target)
                        report_mismatch($sformatf("target %0d, wanted %0d",
                                                  rsp_ch.target, want.target));
                    if (rsp_ch.value !== want.value)
                        report_mismatch($sformatf("target %0d value 0x%0h, wanted 0x%0h",
                                                  want.target, rsp_ch.value, want.value));
                    if (rsp_ch.duty_index !== want.duty_index)
                        report_mismatch($sformatf("duty_index %0d, wanted %0d",
                                                  rsp_ch.duty_index, want.duty_index));
                    if (rsp_ch.last !== want.last)
                        report_mismatch($sformatf("target %0d last %0b, wanted %0b",
                                                  want.target, rsp_ch.last, want.last));
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                seen.kind        = req_ch.kind;
                seen.color       = req_ch.color;
                seen.flash_timed = req_ch.flash_timed;
                seen.on_time_ms  = req_ch.on_time_ms;
                seen.off_time_ms = req_ch.off_time_ms;
                predict_writes(seen);
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("led_light_priority_sequencer test failed");
        $finish;
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        req_ch.valid       = 1'b0;
        req_ch.kind        = '0;
        req_ch.color       = '0;
        req_ch.flash_timed = 1'b0;
        req_ch.on_time_ms  = '0;
        req_ch.off_time_ms = '0;
        rsp_ch.ready       = 1'b0;
        panel_max_shadow   = PANEL_MAX_RESET;
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            src_color[i] = '0;
            src_on[i]    = '0;
            src_off[i]   = '0;
        end
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, panel maximum still at its reset value.
        add_req(KIND_BACKLIGHT, 32'h00ff_ffff, 1'b0, 24'd0, 24'd0);
        add_req(KIND_BACKLIGHT, 32'hff00_0000, 1'b1, 24'hff_ffff, 24'hff_ffff);
        add_req(KIND_BACKLIGHT, 32'h00ff_0000, 1'b0, 24'd0, 24'd0);
        add_req(KIND_BACKLIGHT, 32'h0000_ff00, 1'b0, 24'd0, 24'd0);
        add_req(KIND_BACKLIGHT, 32'h0000_00ff, 1'b0, 24'd0, 24'd0);
        add_req(KIND_UNSUP_LO, 32'h1234_5678, 1'b0, 24'd10, 24'd10);
        add_req(KIND_UNSUP_HI, 32'hffff_ffff, 1'b1, 24'hff_ffff, 24'hff_ffff);
        // Battery level right at the low threshold, then just above it.
        add_req(KIND_BATTERY, 32'h0a00_ff00, 1'b0, 24'd0, 24'd0);
        add_req(KIND_BATTERY, 32'h0b00_ff00, 1'b0, 24'd0, 24'd0);
        add_req(KIND_BATTERY, 32'hff00_0001, 1'b1, 24'd2000, 24'd2000);
        add_req(KIND_ATTENTION, 32'h80ff_ffff, 1'b0, 24'd1000, 24'd1000);
        add_req(KIND_ATTENTION, 32'hff00_00ff, 1'b1, 24'd1600, 24'd500);
        // Short on times shrink the step and drop the high pause.
        add_req(KIND_NOTIFY, 32'h4000_0100, 1'b1, 24'd100, 24'd1);
        add_req(KIND_NOTIFY, 32'hc000_0100, 1'b1, 24'd800, 24'd300);
        add_req(KIND_NOTIFY, 32'hc000_0100, 1'b1, 24'd799, 24'd300);
        add_req(KIND_NOTIFY, 32'hffff_ffff, 1'b1, 24'hff_ffff, 24'hff_ffff);
        add_req(KIND_NOTIFY, 32'h7f00_0010, 1'b1, 24'd500, 24'd0);
        add_req(KIND_NOTIFY, 32'h0012_3456, 1'b0, 24'hff_ffff, 24'hff_ffff);
        add_req(KIND_NOTIFY, 32'h0101_0101, 1'b1, 24'd1, 24'd1);
        // Unlighting sources one by one walks down the priority order.
        add_req(KIND_NOTIFY, 32'hff00_0000, 1'b1, 24'd900, 24'd900);
        add_req(KIND_ATTENTION, 32'h0000_0000, 1'b0, 24'd0, 24'd0);
        add_req(KIND_BATTERY, 32'h00ff_ffff, 1'b0, 24'd0, 24'd0);
        add_req(KIND_BATTERY, 32'h0500_0000, 1'b0, 24'd0, 24'd0);
        drain();

        // Full-scale panel; the result side holds off while requests keep coming.
        write_panel_max(12'd4095);
        queue_random(60);
        rsp_hold_left = HOLD_CYCLES;
        drain();

        write_panel_max(12'd1);
        no_idle = 1'b1;
        queue_random(80);
        drain();
        no_idle = 1'b0;

        write_panel_max(12'd0);
        queue_random(50);
        drain();

        write_panel_max(12'd256);
        queue_random(50);
        drain();

        write_panel_max(12'd254);
        queue_random(50);
        drain();

        write_panel_max(PANEL_MAX_RESET);
        queue_random(70);
        drain();

        write_panel_max(MAX_W'($urandom_range(4095, 1)));
        queue_random(70);
        drain();

        if (error_count == 0)
            $display("led_light_priority_sequencer test passed");
        else
            $display("led_light_priority_sequencer test failed");
        $finish;
    end

endmodule
